FILE: hdl/orsfs_pkg.sv
// ----------------------------------------------------------------------------
// orsfs_pkg: shared types and constants of the OOK remote switch frame sender
// Holds the register map, the register reset values, the configuration
// bundle and the status bundle passed from the sequencer to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package orsfs_pkg;

    // Default values of the top-level parameters.
    localparam int SENDER_BITS_DEF = 26;
    localparam int TIMER_WIDTH_DEF = 20;

    // Number of unit code bits sent at the end of the data word of each frame.
    localparam int UNIT_BITS = 4;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_PULSE = 3'd0,
        CFG_LONG_LOW    = 3'd1,
        CFG_LATCH_LONG  = 3'd2,
        CFG_LATCH_SHORT = 3'd3,
        CFG_GAP_SHORT   = 3'd4,
        CFG_GAP_LONG    = 3'd5,
        CFG_GROUPS      = 3'd6,
        CFG_UNIT        = 3'd7
    } t_cfg_idx;

    // Register reset values.
    localparam logic [15:0]          RST_SHORT_PULSE = 16'd275;
    localparam logic [15:0]          RST_LONG_LOW    = 16'd1225;
    localparam logic [15:0]          RST_LATCH_LONG  = 16'd9900;
    localparam logic [15:0]          RST_LATCH_SHORT = 16'd2675;
    localparam logic [19:0]          RST_GAP_SHORT   = 20'd10000;
    localparam logic [19:0]          RST_GAP_LONG    = 20'd90000;
    localparam logic [3:0]           RST_GROUPS      = 4'd3;
    localparam logic [UNIT_BITS-1:0] RST_UNIT        = 4'd2;

    // All configuration registers as one bundle.
    typedef struct packed {
        logic [15:0]          short_pulse_ticks;
        logic [15:0]          long_low_ticks;
        logic [15:0]          latch_long_ticks;
        logic [15:0]          latch_short_ticks;
        logic [19:0]          gap_short_ticks;
        logic [19:0]          gap_long_ticks;
        logic [3:0]           group_repeats;
        logic [UNIT_BITS-1:0] unit_code;
    } t_cfg;

    // Sequencer status after the request in hand has been applied.
    typedef struct packed {
        logic pin_level;
        logic busy;
    } t_seq_status;

endpackage

`default_nettype wire

FILE: hdl/orsfs_cfg.sv
// ----------------------------------------------------------------------------
// orsfs_cfg: configuration register file
// Eight write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module orsfs_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [orsfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [orsfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output orsfs_pkg::t_cfg                        o_cfg
);

    orsfs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_pulse_ticks <= orsfs_pkg::RST_SHORT_PULSE;
            r_cfg.long_low_ticks    <= orsfs_pkg::RST_LONG_LOW;
            r_cfg.latch_long_ticks  <= orsfs_pkg::RST_LATCH_LONG;
            r_cfg.latch_short_ticks <= orsfs_pkg::RST_LATCH_SHORT;
            r_cfg.gap_short_ticks   <= orsfs_pkg::RST_GAP_SHORT;
            r_cfg.gap_long_ticks    <= orsfs_pkg::RST_GAP_LONG;
            r_cfg.group_repeats     <= orsfs_pkg::RST_GROUPS;
            r_cfg.unit_code         <= orsfs_pkg::RST_UNIT;
        end else if (i_cfg_we) begin
            case (orsfs_pkg::t_cfg_idx'(i_cfg_idx))
                orsfs_pkg::CFG_SHORT_PULSE: r_cfg.short_pulse_ticks <= i_cfg_data[15:0];
                orsfs_pkg::CFG_LONG_LOW:    r_cfg.long_low_ticks    <= i_cfg_data[15:0];
                orsfs_pkg::CFG_LATCH_LONG:  r_cfg.latch_long_ticks  <= i_cfg_data[15:0];
                orsfs_pkg::CFG_LATCH_SHORT: r_cfg.latch_short_ticks <= i_cfg_data[15:0];
                orsfs_pkg::CFG_GAP_SHORT:   r_cfg.gap_short_ticks   <= i_cfg_data[19:0];
                orsfs_pkg::CFG_GAP_LONG:    r_cfg.gap_long_ticks    <= i_cfg_data[19:0];
                orsfs_pkg::CFG_GROUPS:      r_cfg.group_repeats     <= i_cfg_data[3:0];
                orsfs_pkg::CFG_UNIT:        r_cfg.unit_code <= i_cfg_data[orsfs_pkg::UNIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/orsfs_seq.sv
// ----------------------------------------------------------------------------
// orsfs_seq: segment timer and frame sequencer
// Holds the burst state and applies one tick or start request per step.
// The status output shows the state as it will be after the current step.
// ----------------------------------------------------------------------------
`default_nettype none

module orsfs_seq #(
    parameter int SENDER_BITS = orsfs_pkg::SENDER_BITS_DEF,
    parameter int TIMER_WIDTH = orsfs_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_action,
    input  wire logic                   i_switch_on,
    input  wire logic [SENDER_BITS-1:0] i_sender_id,
    input  wire orsfs_pkg::t_cfg        i_cfg,
    output orsfs_pkg::t_seq_status      o_status
);

    localparam int PAIR_COUNT = SENDER_BITS + 2 + orsfs_pkg::UNIT_BITS;
    localparam int IDX_W      = $clog2(PAIR_COUNT);
    localparam int TW         = TIMER_WIDTH;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PRE   = 3'd1,
        PH_DATA  = 3'd2,
        PH_TRAIL = 3'd3,
        PH_GAP   = 3'd4
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [TW-1:0]          r_time, n_time;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_half, n_half;
    logic                   r_low, n_low;
    logic [1:0]             r_frame, n_frame;
    logic [3:0]             r_groups, n_groups;
    logic [SENDER_BITS-1:0] r_sender, n_sender;
    logic                   r_on, n_on;
    logic                   r_pin, n_pin;

    // Segment lengths brought to the timer width.
    logic [31:0]      w_short_ext, w_long_ext, w_lat_long_ext, w_lat_short_ext;
    logic [31:0]      w_gap_s_ext, w_gap_l_ext;
    logic [TW-1:0]    w_short_t, w_long_t, w_lat_long_t, w_lat_short_t;
    logic [TW-1:0]    w_gap_t;

    // Data word sent as Manchester pairs, first pair in the top bit.
    logic [PAIR_COUNT-1:0] w_word;
    logic [IDX_W-1:0]      w_sel;
    logic                  w_bitval;

    logic          seg_load;
    logic          seg_level;
    logic [TW-1:0] seg_ticks;
    logic          frame_start;
    logic          frame_end;

    assign w_short_ext     = {16'd0, i_cfg.short_pulse_ticks};
    assign w_long_ext      = {16'd0, i_cfg.long_low_ticks};
    assign w_lat_long_ext  = {16'd0, i_cfg.latch_long_ticks};
    assign w_lat_short_ext = {16'd0, i_cfg.latch_short_ticks};
    assign w_gap_s_ext     = {12'd0, i_cfg.gap_short_ticks};
    assign w_gap_l_ext     = {12'd0, i_cfg.gap_long_ticks};

    assign w_short_t     = w_short_ext[TW-1:0];
    assign w_long_t      = w_long_ext[TW-1:0];
    assign w_lat_long_t  = w_lat_long_ext[TW-1:0];
    assign w_lat_short_t = w_lat_short_ext[TW-1:0];
    assign w_gap_t       = (r_frame == 2'd1) ? w_gap_l_ext[TW-1:0] : w_gap_s_ext[TW-1:0];

    assign w_word   = {r_sender, 1'b0, r_on, i_cfg.unit_code};
    assign w_sel    = IDX_W'(PAIR_COUNT - 1) - r_idx;
    assign w_bitval = w_word[w_sel] ^ r_half;

    always_comb begin
        n_phase     = r_phase;
        n_time      = r_time;
        n_idx       = r_idx;
        n_half      = r_half;
        n_low       = r_low;
        n_frame     = r_frame;
        n_groups    = r_groups;
        n_sender    = r_sender;
        n_on        = r_on;
        n_pin       = r_pin;
        seg_load    = 1'b0;
        seg_level   = 1'b0;
        seg_ticks   = w_short_t;
        frame_start = 1'b0;
        frame_end   = 1'b0;

        if (i_step) begin
            if (i_action) begin
                // A start request only opens a burst from idle and with a nonzero group count.
                if (r_phase == PH_IDLE && i_cfg.group_repeats != 4'd0) begin
                    n_on        = i_switch_on;
                    n_sender    = i_sender_id;
                    n_groups    = i_cfg.group_repeats;
                    n_frame     = 2'd0;
                    frame_start = 1'b1;
                end
            end else if (r_phase != PH_IDLE) begin
                if (r_time > TW'(1)) begin
                    n_time = r_time - TW'(1);
                end else begin
                    case (r_phase)
                        PH_PRE: begin
                            if (r_idx < IDX_W'(3)) begin
                                n_idx    = r_idx + IDX_W'(1);
                                seg_load = 1'b1;
                                if (r_idx == IDX_W'(0)) begin
                                    seg_level = 1'b0;
                                    seg_ticks = w_lat_long_t;
                                end else if (r_idx == IDX_W'(1)) begin
                                    seg_level = 1'b1;
                                    seg_ticks = w_short_t;
                                end else begin
                                    seg_level = 1'b0;
                                    seg_ticks = w_lat_short_t;
                                end
                            end else begin
                                n_phase   = PH_DATA;
                                n_idx     = '0;
                                n_half    = 1'b0;
                                n_low     = 1'b0;
                                seg_load  = 1'b1;
                                seg_level = 1'b1;
                                seg_ticks = w_short_t;
                            end
                        end
                        PH_DATA: begin
                            seg_load = 1'b1;
                            if (!r_low) begin
                                n_low     = 1'b1;
                                seg_level = 1'b0;
                                seg_ticks = w_bitval ? w_long_t : w_short_t;
                            end else begin
                                n_low     = 1'b0;
                                seg_level = 1'b1;
                                seg_ticks = w_short_t;
                                if (!r_half) begin
                                    n_half = 1'b1;
                                end else begin
                                    n_half = 1'b0;
                                    if (r_idx == IDX_W'(PAIR_COUNT - 1)) begin
                                        n_phase = PH_TRAIL;
                                        n_idx   = '0;
                                    end else begin
                                        n_idx = r_idx + IDX_W'(1);
                                    end
                                end
                            end
                        end
                        PH_TRAIL: begin
                            if (!r_low) begin
                                n_low     = 1'b1;
                                seg_load  = 1'b1;
                                seg_level = 1'b0;
                                seg_ticks = w_lat_short_t;
                            end else begin
                                n_low = 1'b0;
                                if (w_gap_t != '0) begin
                                    n_phase   = PH_GAP;
                                    seg_load  = 1'b1;
                                    seg_level = 1'b0;
                                    seg_ticks = w_gap_t;
                                end else begin
                                    frame_end = 1'b1;
                                end
                            end
                        end
                        PH_GAP: begin
                            frame_end = 1'b1;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_time  = '0;
                            n_pin   = 1'b0;
                        end
                    endcase
                end
            end
        end

        // Frame boundary: next frame of the group, next group, or burst end.
        if (frame_end) begin
            if (r_frame != 2'd3) begin
                n_frame     = r_frame + 2'd1;
                frame_start = 1'b1;
            end else begin
                n_frame  = 2'd0;
                n_groups = r_groups - 4'd1;
                if (n_groups != 4'd0) begin
                    frame_start = 1'b1;
                end else begin
                    n_phase = PH_IDLE;
                    n_time  = '0;
                    n_idx   = '0;
                    n_half  = 1'b0;
                    n_low   = 1'b0;
                    n_pin   = 1'b0;
                end
            end
        end

        if (frame_start) begin
            n_phase   = PH_PRE;
            n_idx     = '0;
            n_half    = 1'b0;
            n_low     = 1'b0;
            seg_load  = 1'b1;
            seg_level = 1'b1;
            seg_ticks = w_short_t;
        end

        // A zero length segment still lasts one tick.
        if (seg_load) begin
            n_pin  = seg_level;
            n_time = (seg_ticks == '0) ? TW'(1) : seg_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_time   <= '0;
            r_idx    <= '0;
            r_half   <= 1'b0;
            r_low    <= 1'b0;
            r_frame  <= 2'd0;
            r_groups <= 4'd0;
            r_sender <= '0;
            r_on     <= 1'b0;
            r_pin    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_time   <= n_time;
            r_idx    <= n_idx;
            r_half   <= n_half;
            r_low    <= n_low;
            r_frame  <= n_frame;
            r_groups <= n_groups;
            r_sender <= n_sender;
            r_on     <= n_on;
            r_pin    <= n_pin;
        end
    end

    assign o_status.pin_level = n_pin;
    assign o_status.busy      = (n_phase != PH_IDLE);

endmodule

`default_nettype wire

FILE: hdl/ook_remote_switch_frame_sender.sv
// ----------------------------------------------------------------------------
// ook_remote_switch_frame_sender: on-off-keyed remote switch transmitter
// Steps out bursts of Manchester coded switch frames on one radio pin.
// ----------------------------------------------------------------------------
// Each request on the input channel is either a start command or one
// microsecond tick, and each request yields exactly one result holding the
// transmitter pin level and the busy flag as they stand after that request.
// A start command taken while idle latches the sender code and the on/off
// flag and opens a burst of group_repeats groups of four frames; ticks then
// time every high and low segment of the preamble, the data pairs (32 by
// default), the trailer and the gap that follows each frame. A start command
// while busy and a tick while idle change nothing. The block takes one
// request per clock cycle while the consumer keeps up: a request is held in
// an input register, the sequencer applies it once the result register can
// take its outcome, so a result is valid in the cycle after its request is
// applied. The result register only stops the flow when it is full and the
// consumer does not take it. Configuration writes go to a separate write
// port and must be made while no burst is running.
// ----------------------------------------------------------------------------
`default_nettype none

module ook_remote_switch_frame_sender #(
    parameter int SENDER_BITS = orsfs_pkg::SENDER_BITS_DEF,
    parameter int TIMER_WIDTH = orsfs_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Request channel.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_action,
    input  wire logic                              i_switch_on,
    input  wire logic [SENDER_BITS-1:0]            i_sender_id,
    // Result channel.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_pin_level,
    output logic                                   o_busy_res,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [orsfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [orsfs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    orsfs_pkg::t_cfg        w_cfg;
    orsfs_pkg::t_seq_status w_status;

    // Input register.
    logic                   r_in_valid;
    logic                   r_action;
    logic                   r_switch_on;
    logic [SENDER_BITS-1:0] r_sender_id;

    // Result register.
    logic r_out_valid;
    logic r_pin_level;
    logic r_busy_res;

    // The held request is applied when the result register can take its outcome.
    logic w_step;

    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    orsfs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    orsfs_seq #(
        .SENDER_BITS (SENDER_BITS),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_action    (r_action),
        .i_switch_on (r_switch_on),
        .i_sender_id (r_sender_id),
        .i_cfg       (w_cfg),
        .o_status    (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action    <= i_action;
            r_switch_on <= i_switch_on;
            r_sender_id <= i_sender_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_pin_level <= w_status.pin_level;
            r_busy_res  <= w_status.busy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pin_level = r_pin_level;
    assign o_busy_res  = r_busy_res;

    // The carrier is never left on once a burst has ended.
    a_idle_pin_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res) |-> !o_pin_level)
        else $error("pin high while no burst is running");

    // An empty result register never holds back the request channel.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request channel stalled with empty result register");

    // Every applied request produces a result in the next cycle.
    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_out_valid)
        else $error("applied request did not produce a result");

endmodule

`default_nettype wire
